// ----- rtl/yqr_pkg.sv -----
// Shared constants and build-time term function for the YUV 4:2:0 quad to RGB converter.
// No dependencies.
package yqr_pkg;

  localparam int COEF_Y  = 1164;
  localparam int COEF_RV = 1596;
  localparam int COEF_GU = 391;
  localparam int COEF_GV = 813;
  localparam int COEF_BU = 2018;

  localparam int LUMA_OFFSET   = 16;
  localparam int CHROMA_OFFSET = 128;
  localparam int MILLI         = 1000;
  localparam int ROUND_HALF    = 500;

  localparam int SAMPLE_W    = 8;
  localparam int TABLE_DEPTH = 256;

  // Evaluated at elaboration only: trunc((coef * 2^frac + 0.5 * 1000) * n / 1000).
  function automatic longint coef_term(input int coef_milli, input int n, input int frac);
    longint k;
    longint prod;
    k    = longint'(coef_milli) * (longint'(1) <<< frac) + longint'(ROUND_HALF);
    prod = k * longint'(n);
    return prod / MILLI;
  endfunction

endpackage

// ----- rtl/yqr_pixel.sv -----
// One pixel: combines luma term with chroma terms (green subtracts), scales down and clamps each channel.
// Depends on yqr_pkg.
module yqr_pixel #(
  parameter int FRACTION_BITS = 13,
  parameter int TW = FRACTION_BITS + 10,
  parameter int SW = FRACTION_BITS + 12
) (
  input  logic signed [TW-1:0] y_term,
  input  logic signed [TW-1:0] rv_term,
  input  logic signed [TW-1:0] guv_term,
  input  logic signed [TW-1:0] bu_term,
  output logic [yqr_pkg::SAMPLE_W-1:0] red,
  output logic [yqr_pkg::SAMPLE_W-1:0] green,
  output logic [yqr_pkg::SAMPLE_W-1:0] blue
);

  function automatic logic [yqr_pkg::SAMPLE_W-1:0] clamp_ch(input logic signed [SW-1:0] s);
    logic signed [SW-1:0] sh;
    sh = s >>> FRACTION_BITS;
    if (sh[SW-1]) begin
      return '0;
    end else if (|sh[SW-2:yqr_pkg::SAMPLE_W]) begin
      return '1;
    end else begin
      return sh[yqr_pkg::SAMPLE_W-1:0];
    end
  endfunction

  logic signed [SW-1:0] y_ext;
  logic signed [SW-1:0] r_sum;
  logic signed [SW-1:0] g_sum;
  logic signed [SW-1:0] b_sum;

  always_comb begin
    y_ext = SW'(y_term);
    r_sum = y_ext + SW'(rv_term);
    g_sum = y_ext - SW'(guv_term);
    b_sum = y_ext + SW'(bu_term);
    red   = clamp_ch(r_sum);
    green = clamp_ch(g_sum);
    blue  = clamp_ch(b_sum);
  end

endmodule

// ----- rtl/yuv420_quad_to_rgb.sv -----
// Top level: converts one 2x2 luma quad with shared U/V to RGB for four pixels.
// Depends on yqr_pkg and yqr_pixel.
// Pipeline: an accepted item passes the term register, then the result register.
// Throughput: one item per cycle while the output is not stalled; the term lookups and
// per-pixel add/clamp each take one register stage; a stage loads when empty or read.
// Reset: synchronous, clears both stage valid bits; data registers are not reset.
module yuv420_quad_to_rgb #(
  parameter int FRACTION_BITS = 13
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] luma_top_left,
  input  logic [7:0] luma_top_right,
  input  logic [7:0] luma_bottom_left,
  input  logic [7:0] luma_bottom_right,
  input  logic [7:0] chroma_blue,
  input  logic [7:0] chroma_red,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] red_top_left,
  output logic [7:0] green_top_left,
  output logic [7:0] blue_top_left,
  output logic [7:0] red_top_right,
  output logic [7:0] green_top_right,
  output logic [7:0] blue_top_right,
  output logic [7:0] red_bottom_left,
  output logic [7:0] green_bottom_left,
  output logic [7:0] blue_bottom_left,
  output logic [7:0] red_bottom_right,
  output logic [7:0] green_bottom_right,
  output logic [7:0] blue_bottom_right
);

  localparam int TW = FRACTION_BITS + 10;
  localparam int SW = FRACTION_BITS + 12;
  localparam int NPIX = 4;
  localparam int DEPTH = yqr_pkg::TABLE_DEPTH;

  // constant term tables
  logic signed [TW-1:0] tbl_y  [DEPTH];
  logic signed [TW-1:0] tbl_rv [DEPTH];
  logic signed [TW-1:0] tbl_gu [DEPTH];
  logic signed [TW-1:0] tbl_gv [DEPTH];
  logic signed [TW-1:0] tbl_bu [DEPTH];

  for (genvar i = 0; i < DEPTH; i++) begin : g_tbl
    localparam longint TY = yqr_pkg::coef_term(yqr_pkg::COEF_Y,
                                               i - yqr_pkg::LUMA_OFFSET, FRACTION_BITS);
    localparam longint TRV = yqr_pkg::coef_term(yqr_pkg::COEF_RV,
                                                i - yqr_pkg::CHROMA_OFFSET, FRACTION_BITS);
    localparam longint TGU = yqr_pkg::coef_term(yqr_pkg::COEF_GU,
                                                i - yqr_pkg::CHROMA_OFFSET, FRACTION_BITS);
    localparam longint TGV = yqr_pkg::coef_term(yqr_pkg::COEF_GV,
                                                i - yqr_pkg::CHROMA_OFFSET, FRACTION_BITS);
    localparam longint TBU = yqr_pkg::coef_term(yqr_pkg::COEF_BU,
                                                i - yqr_pkg::CHROMA_OFFSET, FRACTION_BITS);
    assign tbl_y[i]  = TW'(TY);
    assign tbl_rv[i] = TW'(TRV);
    assign tbl_gu[i] = TW'(TGU);
    assign tbl_gv[i] = TW'(TGV);
    assign tbl_bu[i] = TW'(TBU);
  end

  // handshake
  logic v1;
  logic ready2;
  logic ready1;
  logic take_in;
  logic adv1;

  assign ready2   = !out_valid || !out_stall;
  assign ready1   = !v1 || ready2;
  assign in_stall = !ready1;
  assign take_in  = in_valid && ready1;
  assign adv1     = v1 && ready2;

  // stage 1: term registers
  logic signed [TW-1:0] y_term [NPIX];
  logic signed [TW-1:0] rv_term;
  logic signed [TW-1:0] guv_term;
  logic signed [TW-1:0] bu_term;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (ready1) begin
      v1 <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (take_in) begin
      y_term[0] <= tbl_y[luma_top_left];
      y_term[1] <= tbl_y[luma_top_right];
      y_term[2] <= tbl_y[luma_bottom_left];
      y_term[3] <= tbl_y[luma_bottom_right];
      rv_term   <= tbl_rv[chroma_red];
      guv_term  <= tbl_gu[chroma_blue] + tbl_gv[chroma_red];
      bu_term   <= tbl_bu[chroma_blue];
    end
  end

  // stage 2: per-pixel channels
  logic [7:0] r_next [NPIX];
  logic [7:0] g_next [NPIX];
  logic [7:0] b_next [NPIX];

  for (genvar p = 0; p < NPIX; p++) begin : g_pix
    yqr_pixel #(
      .FRACTION_BITS(FRACTION_BITS),
      .TW(TW),
      .SW(SW)
    ) u_pix (
      .y_term  (y_term[p]),
      .rv_term (rv_term),
      .guv_term(guv_term),
      .bu_term (bu_term),
      .red     (r_next[p]),
      .green   (g_next[p]),
      .blue    (b_next[p])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (ready2) begin
      out_valid <= v1;
    end
  end

  always_ff @(posedge clk) begin
    if (adv1) begin
      red_top_left       <= r_next[0];
      green_top_left     <= g_next[0];
      blue_top_left      <= b_next[0];
      red_top_right      <= r_next[1];
      green_top_right    <= g_next[1];
      blue_top_right     <= b_next[1];
      red_bottom_left    <= r_next[2];
      green_bottom_left  <= g_next[2];
      blue_bottom_left   <= b_next[2];
      red_bottom_right   <= r_next[3];
      green_bottom_right <= g_next[3];
      blue_bottom_right  <= b_next[3];
    end
  end

endmodule

// ----- rtl/yqr_checker.sv -----
// Port-level checks for yuv420_quad_to_rgb, attached by bind.
// No package dependencies.
module yqr_checker (
  input logic       clk,
  input logic       rst,
  input logic       in_valid,
  input logic       in_stall,
  input logic       out_valid,
  input logic       out_stall,
  input logic [7:0] red_top_left,
  input logic [7:0] green_top_left,
  input logic [7:0] blue_bottom_right
);

  // stalled result stays put
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(red_top_left)
      && $stable(green_top_left) && $stable(blue_bottom_right))
    else $error("stalled result changed");

  // input backpressure only comes from a stalled, full output
  a_stall_src: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> out_valid && out_stall)
    else $error("input stalled without output backpressure");

  // no result right after reset
  a_reset_empty: assert property (@(posedge clk)
    $past(rst) |-> !out_valid)
    else $error("result valid after reset");

  // an item accepted while the output stays open reaches the output
  a_latency: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall && !out_stall ##1 !out_stall |=> out_valid)
    else $error("accepted item did not reach output");

endmodule

bind yuv420_quad_to_rgb yqr_checker u_yqr_checker (
  .clk              (clk),
  .rst              (rst),
  .in_valid         (in_valid),
  .in_stall         (in_stall),
  .out_valid        (out_valid),
  .out_stall        (out_stall),
  .red_top_left     (red_top_left),
  .green_top_left   (green_top_left),
  .blue_bottom_right(blue_bottom_right)
);
